[rtl/core/itda_pkg.sv]
// itda_pkg: shared types and constants for the integer to decimal ASCII block.
// Used by itda_front, itda_fifo, itda_back and int_to_decimal_ascii.
`default_nettype none

package itda_pkg;

  localparam int          VALUE_W        = 32;
  localparam int          CHAR_W         = 8;
  localparam int          DIG_W          = 4;
  localparam int          MAX_DIGITS     = 10;
  localparam int          NDIG_W         = $clog2(MAX_DIGITS + 1);
  localparam int          QUEUE_DEPTH_DEF = 2;

  localparam logic [CHAR_W-1:0]  CH_ZERO     = 8'd48;
  localparam logic [CHAR_W-1:0]  CH_MINUS    = 8'd45;
  // floor(x / 10) == (x * DIV10_RECIP) >> DIV10_SHIFT for every 32-bit x
  localparam logic [VALUE_W-1:0] DIV10_RECIP = 32'hCCCC_CCCD;
  localparam int                 DIV10_SHIFT = 35;
  localparam int                 QUOT_W      = 2 * VALUE_W - DIV10_SHIFT;

  typedef struct packed {
    logic                             neg;
    logic [NDIG_W-1:0]                ndig;
    logic [MAX_DIGITS-1:0][DIG_W-1:0] digits;
  } entry_t;

  typedef enum logic [1:0] {
    FE_IDLE,
    FE_MUL,
    FE_REM,
    FE_PUSH
  } fe_state_t;

endpackage

`default_nettype wire

[rtl/core/itda_front.sv]
// itda_front: takes an input word, splits off sign and magnitude and extracts
// decimal digits least significant first. Depends on itda_pkg.
`default_nettype none

module itda_front
  import itda_pkg::*;
(
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_valid,
  output logic                           in_stall,
  input  wire logic signed [VALUE_W-1:0] in_value,
  output logic                           push_valid,
  input  wire logic                      q_full,
  output entry_t                         push_data
);

  fe_state_t                        state_r, state_nxt;
  logic                             neg_r;
  logic [VALUE_W-1:0]               mag_r;
  logic [QUOT_W-1:0]                q_r;
  logic [NDIG_W-1:0]                ndig_r;
  logic [MAX_DIGITS-1:0][DIG_W-1:0] digits_r;
  logic [VALUE_W-1:0]               val_u;
  logic [2*VALUE_W-1:0]             prod;
  logic [VALUE_W-1:0]               rem;

  assign val_u = in_value;
  assign prod  = mag_r * DIV10_RECIP;
  assign rem   = mag_r - VALUE_W'({q_r, 3'b000}) - VALUE_W'({q_r, 1'b0});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= FE_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      FE_IDLE: begin
        if (in_valid) begin
          neg_r  <= val_u[VALUE_W-1];
          mag_r  <= val_u[VALUE_W-1] ? (~val_u + VALUE_W'(1)) : val_u;
          ndig_r <= '0;
        end
      end
      FE_MUL: begin
        q_r <= prod[2*VALUE_W-1:DIV10_SHIFT];
      end
      FE_REM: begin
        digits_r[ndig_r] <= rem[DIG_W-1:0];
        ndig_r           <= ndig_r + NDIG_W'(1);
        mag_r            <= VALUE_W'(q_r);
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    state_nxt        = state_r;
    in_stall         = (state_r != FE_IDLE);
    push_valid       = (state_r == FE_PUSH);
    push_data.neg    = neg_r;
    push_data.ndig   = ndig_r;
    push_data.digits = digits_r;
    unique case (state_r)
      FE_IDLE: begin
        if (in_valid) state_nxt = FE_MUL;
      end
      FE_MUL: begin
        state_nxt = FE_REM;
      end
      FE_REM: begin
        if (q_r == '0 || ndig_r == NDIG_W'(MAX_DIGITS - 1)) begin
          state_nxt = FE_PUSH;
        end else begin
          state_nxt = FE_MUL;
        end
      end
      FE_PUSH: begin
        if (!q_full) state_nxt = FE_IDLE;
      end
      default: state_nxt = FE_IDLE;
    endcase
  end

  a_ndig_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == FE_REM |-> ndig_r < NDIG_W'(MAX_DIGITS))
    else $error("digit count overrun");

  a_push_has_digit: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == FE_PUSH |-> ndig_r != '0)
    else $error("entry pushed without digits");

endmodule

`default_nettype wire

[rtl/core/itda_fifo.sv]
// itda_fifo: short queue of converted entries between front and back.
// Depends on itda_pkg.
`default_nettype none

module itda_fifo
  import itda_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire logic   wr_valid,
  input  wire entry_t wr_data,
  output logic        full,
  output logic        rd_valid,
  input  wire logic   rd_take,
  output entry_t      rd_data
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  entry_t        mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] count_r;
  logic          push, pop;

  assign full     = (count_r == CW'(DEPTH));
  assign rd_valid = (count_r != '0);
  assign rd_data  = mem_r[rd_ptr_r];
  assign push     = wr_valid && !full;
  assign pop      = rd_valid && rd_take;

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
      end
      if (push && !pop) begin
        count_r <= count_r + CW'(1);
      end else if (pop && !push) begin
        count_r <= count_r - CW'(1);
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("queue count overflow");

  a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
    count_r == '0 |-> wr_ptr_r == rd_ptr_r)
    else $error("queue pointers disagree with count");

endmodule

`default_nettype wire

[rtl/core/itda_back.sv]
// itda_back: takes queued entries and emits sign and digits, most significant
// first, through a registered output word. Depends on itda_pkg.
`default_nettype none

module itda_back
  import itda_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              q_valid,
  input  wire entry_t            q_data,
  output logic                   q_take,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic [CHAR_W-1:0]      out_character,
  output logic                   out_last
);

  entry_t            ent_r;
  logic              busy_r, sign_pend_r, out_valid_r;
  logic [NDIG_W-1:0] idx_r;
  logic [CHAR_W-1:0] char_r;
  logic              last_r;
  logic              load;

  assign q_take        = !busy_r;
  assign load          = busy_r && (!out_valid_r || !out_stall);
  assign out_valid     = out_valid_r;
  assign out_character = char_r;
  assign out_last      = last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      sign_pend_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (!busy_r && q_valid) begin
        busy_r      <= 1'b1;
        sign_pend_r <= q_data.neg;
      end else if (load) begin
        if (sign_pend_r) begin
          sign_pend_r <= 1'b0;
        end else if (idx_r == '0) begin
          busy_r <= 1'b0;
        end
      end
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!busy_r && q_valid) begin
      ent_r <= q_data;
      idx_r <= q_data.ndig - NDIG_W'(1);
    end else if (load) begin
      if (sign_pend_r) begin
        char_r <= CH_MINUS;
        last_r <= 1'b0;
      end else begin
        char_r <= CH_ZERO + CHAR_W'(ent_r.digits[idx_r]);
        last_r <= (idx_r == '0);
        idx_r  <= idx_r - NDIG_W'(1);
      end
    end
  end

  a_sign_in_run: assert property (@(posedge clk) disable iff (!rst_n)
    sign_pend_r |-> busy_r)
    else $error("sign pending outside a run");

  a_last_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
    load && !sign_pend_r && idx_r == '0 |=> !busy_r && out_last)
    else $error("run did not end on last digit");

endmodule

`default_nettype wire

[rtl/core/int_to_decimal_ascii.sv]
// int_to_decimal_ascii: top level, signed 32-bit integer to decimal ASCII text.
// Instantiates itda_front, itda_fifo and itda_back; depends on itda_pkg.
//
// Input channel: in_valid / in_stall / in_value, one signed 32-bit word each.
// Output channel: out_valid / out_stall / out_character / out_last, one ASCII
// character per word, '-' first for negatives, then digits most significant
// first; out_last marks the final character of each number (1 to 11 words).
// The front extracts digits by reciprocal multiply, a multiply state and a
// remainder state per digit, and holds in_stall from acceptance until the entry
// is pushed; this loop sets the sustained input rate.
// The back emits one character per cycle from the queue while out_stall is low,
// and fetches each entry from the queue before its first character.
// The queue lets the front convert the next word while the back still emits.
// Reset (rst_n low, synchronous) empties the queue and drops any run.
// A stalled output holds its word; back-pressure fills the queue and then
// raises in_stall.
`default_nettype none

module int_to_decimal_ascii
  import itda_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_valid,
  output logic                           in_stall,
  input  wire logic signed [VALUE_W-1:0] in_value,
  output logic                           out_valid,
  input  wire logic                      out_stall,
  output logic [CHAR_W-1:0]              out_character,
  output logic                           out_last
);

  entry_t push_data, pop_data;
  logic   push_valid, q_full, q_valid, q_take;

  itda_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_value   (in_value),
    .push_valid (push_valid),
    .q_full     (q_full),
    .push_data  (push_data)
  );

  itda_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (push_valid),
    .wr_data  (push_data),
    .full     (q_full),
    .rd_valid (q_valid),
    .rd_take  (q_take),
    .rd_data  (pop_data)
  );

  itda_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_valid       (q_valid),
    .q_data        (pop_data),
    .q_take        (q_take),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_character (out_character),
    .out_last      (out_last)
  );

endmodule

`default_nettype wire
